FILE: hdl/tbdms_pkg.sv
// Shared types, register codes and helpers for the two-button menu stepper.
package tbdms_pkg;

  localparam int TimeW    = 32;
  localparam int CfgW     = 16;
  localparam int CountW   = 9;
  localparam int IndexW   = 8;
  localparam int CfgAddrW = 2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_HOLD       = 2'd1,
    REG_RATE_LIMIT = 2'd2,
    REG_MENU_COUNT = 2'd3
  } cfg_reg_t;

  localparam logic [CfgW-1:0]   DebounceReset  = 16'd20;
  localparam logic [CfgW-1:0]   HoldReset      = 16'd20;
  localparam logic [CfgW-1:0]   RateReset      = 16'd20;
  localparam logic [CountW-1:0] MenuCountReset = 9'd4;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic             right_level;
    logic             left_level;
  } sample_t;

  typedef struct packed {
    logic [IndexW-1:0] menu_index;
    logic              display_update;
    logic              sample_ignored;
  } result_t;

  typedef struct packed {
    logic [CfgW-1:0]   debounce_ms;
    logic [CfgW-1:0]   hold_ms;
    logic [CfgW-1:0]   rate_limit_ms;
    logic [CountW-1:0] menu_count;
  } cfg_t;

  typedef struct packed {
    logic              last_right_level;
    logic              last_left_level;
    logic [TimeW-1:0]  right_stamp;
    logic [TimeW-1:0]  left_stamp;
    logic              right_taken;
    logic              left_taken;
    logic [TimeW-1:0]  change_stamp;
    logic [IndexW-1:0] menu_reg;
    logic              refresh_flag;
  } step_state_t;

  // Highest reachable menu index: a count of zero acts as one menu and
  // counts above 256 clamp to the largest 8-bit index.
  function automatic logic [IndexW-1:0] top_index(input logic [CountW-1:0] count);
    logic [CountW-1:0] less_one;
    less_one = count - 9'd1;
    if (count == '0) begin
      top_index = '0;
    end else if (count > 9'd256) begin
      top_index = '1;
    end else begin
      top_index = less_one[IndexW-1:0];
    end
  endfunction

endpackage

FILE: hdl/tbdms_cfg.sv
// Configuration register file for the menu stepper.
module tbdms_cfg
  import tbdms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgAddrW-1:0] cfg_index,
  input  logic [CfgW-1:0]     cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= DebounceReset;
      cfg.hold_ms       <= HoldReset;
      cfg.rate_limit_ms <= RateReset;
      cfg.menu_count    <= MenuCountReset;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data;
        REG_HOLD:       cfg.hold_ms       <= cfg_data;
        REG_RATE_LIMIT: cfg.rate_limit_ms <= cfg_data;
        REG_MENU_COUNT: cfg.menu_count    <= cfg_data[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/tbdms_step.sv
// Combinational update of the debounce and menu state for one poll sample.
module tbdms_step
  import tbdms_pkg::*;
(
  input  cfg_t        cfg,
  input  step_state_t state,
  input  sample_t     sample,
  output step_state_t state_next,
  output result_t     result
);

  logic [TimeW-1:0]  t;
  logic              skip;
  logic              r_chg;
  logic              l_chg;
  logic [TimeW-1:0]  r_diff;
  logic [TimeW-1:0]  l_diff;
  logic [IndexW-1:0] top;
  step_state_t       s;

  assign t     = sample.time_ms;
  assign top   = top_index(cfg.menu_count);
  assign skip  = (t - state.change_stamp) < {16'd0, cfg.rate_limit_ms};
  assign r_chg = sample.right_level != state.last_right_level;
  assign l_chg = sample.left_level != state.last_left_level;
  // A level change restarts the stamp at this sample, so the age is zero.
  assign r_diff = r_chg ? '0 : (t - state.right_stamp);
  assign l_diff = l_chg ? '0 : (t - state.left_stamp);

  always_comb begin
    s = state;
    if (r_chg) begin
      s.right_stamp = t;
    end
    if (r_diff > {16'd0, cfg.debounce_ms}) begin
      if (!sample.right_level && !state.right_taken) begin
        if (state.menu_reg < top) begin
          s.menu_reg     = state.menu_reg + 8'd1;
          s.refresh_flag = 1'b1;
          s.right_taken  = 1'b1;
          s.right_stamp  = t;
        end
      end else if (sample.right_level) begin
        s.right_taken = 1'b0;
      end
    end else if (state.right_taken && (r_diff < {16'd0, cfg.hold_ms})) begin
      s.refresh_flag = 1'b0;
    end

    // The left button is locked out while the right press is held.
    if (!s.right_taken) begin
      if (l_chg) begin
        s.left_stamp = t;
      end
      if (l_diff > {16'd0, cfg.debounce_ms}) begin
        if (!sample.left_level && !state.left_taken) begin
          if (s.menu_reg != '0) begin
            s.menu_reg     = s.menu_reg - 8'd1;
            s.refresh_flag = 1'b1;
            s.left_taken   = 1'b1;
          end
        end else if (sample.left_level) begin
          s.left_taken = 1'b0;
        end
      end
    end

    if (r_chg || l_chg) begin
      s.change_stamp = t;
    end
    s.last_right_level = sample.right_level;
    s.last_left_level  = sample.left_level;

    state_next = skip ? state : s;
  end

  assign result.menu_index     = state_next.menu_reg;
  assign result.display_update = state_next.refresh_flag;
  assign result.sample_ignored = skip;

endmodule

FILE: hdl/two_button_debounced_menu_stepper_top.sv
// Top level of the two-button debounced menu stepper.
//
// Each request on the input channel is one poll sample: a 32-bit millisecond
// timestamp and the active-low levels of the right and left buttons. Every
// sample yields exactly one result request carrying the menu index, the
// display refresh flag and a flag that tells whether the rate limit skipped
// the sample. The block takes one sample per clock cycle while the output is
// not stalled; a sample lands in an input register, the whole debounce and menu
// update is computed combinationally from there, and the result is written
// into an output register, from which it is offered. A single state update
// reads and writes the debounce state in the same cycle. A result waiting on
// the output does not block the input register from filling; input stall
// rises only when both registers hold requests and the output is stalled.
// Time differences wrap modulo 2^32.
// The four configuration registers (debounce, hold window, rate limit, menu
// count) are written through the plain write port and should be changed only
// while no sample is in flight.
module two_button_debounced_menu_stepper_top
  import tbdms_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sample_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output result_t             out_data,
  input  logic                cfg_write,
  input  logic [CfgAddrW-1:0] cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  cfg_t        cfg;
  step_state_t state;
  step_state_t state_next;
  result_t     step_res;
  sample_t     sample;
  logic        sample_valid;
  logic        out_free;
  logic        advance;

  tbdms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbdms_step u_step (
    .cfg        (cfg),
    .state      (state),
    .sample     (sample),
    .state_next (state_next),
    .result     (step_res)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign advance  = sample_valid && out_free;
  assign in_stall = sample_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!in_stall) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      sample <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_res;
    end
  end

  // Debounce state commits once per processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_right_level <= 1'b1;
      state.last_left_level  <= 1'b1;
      state.right_stamp      <= '0;
      state.left_stamp       <= '0;
      state.right_taken      <= 1'b0;
      state.left_taken       <= 1'b0;
      state.change_stamp     <= '0;
      state.menu_reg         <= '0;
      state.refresh_flag     <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // A skipped sample leaves every piece of state untouched.
  a_skip_holds_state : assert property (@(posedge clk) disable iff (rst)
    (advance && step_res.sample_ignored) |=> (state == $past(state)))
    else $error("skipped sample changed the debounce state");

  // The menu index moves by at most one step per sample.
  a_single_step : assert property (@(posedge clk) disable iff (rst)
    advance |=> ((state.menu_reg == $past(state.menu_reg)) ||
                 (state.menu_reg == $past(state.menu_reg) + 8'd1) ||
                 (state.menu_reg == $past(state.menu_reg) - 8'd1)))
    else $error("menu index jumped by more than one");

  // The refresh flag is only raised together with a menu step.
  a_flag_needs_step : assert property (@(posedge clk) disable iff (rst)
    (advance && state_next.refresh_flag && !state.refresh_flag) |->
      (state_next.menu_reg != state.menu_reg))
    else $error("refresh flag set without a menu step");

endmodule
